// ===== design/tpti_pkg.sv =====
// ----------------------------------------------------------------------------
// tpti_pkg: shared types and constants of the texcoord interpolator
// Beat payloads, sideband flags, datapath widths and register codes.
// ----------------------------------------------------------------------------
package tpti_pkg;

    // configuration register codes (paddr[5:3])
    localparam logic [2:0] REG_VERTEX_A_POS   = 3'd0;
    localparam logic [2:0] REG_VERTEX_B_POS   = 3'd1;
    localparam logic [2:0] REG_VERTEX_C_POS   = 3'd2;
    localparam logic [2:0] REG_VERTEX_A_TEX   = 3'd3;
    localparam logic [2:0] REG_VERTEX_B_TEX   = 3'd4;
    localparam logic [2:0] REG_VERTEX_C_TEX   = 3'd5;
    localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd6;
    localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd7;

    localparam int ADDR_W     = 6;
    localparam int NUM_W      = 80;  // magnitude of u/v numerator
    localparam int DEN_W      = 65;  // magnitude of common denominator
    localparam int ACC_W      = 82;  // divider partial remainder
    localparam int Q_W        = 16;
    localparam int DIV_STAGES = 18;
    localparam int NUM_STAGES = 30;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } pix_t;

    typedef struct packed {
        logic               covered;
        logic               degenerate;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [23:0]        texel_index;
    } res_t;

    typedef struct packed {
        logic covered;
        logic degenerate;
        logic live;
        logic neg_u;
        logic neg_v;
    } side_t;

endpackage

// ===== design/tpti_div.sv =====
// ----------------------------------------------------------------------------
// tpti_div: pipelined rounding divider, two lanes sharing one divisor
// Forms (2n+d)/(2d), flags a quotient of 2^16 or more, then resolves one
// quotient bit per stage by restoring compare and subtract.
// ----------------------------------------------------------------------------
module tpti_div (
    input  logic                                clk,
    input  logic [tpti_pkg::DIV_STAGES-1:0]     en,
    input  logic [tpti_pkg::NUM_W-1:0]          nu,
    input  logic [tpti_pkg::NUM_W-1:0]          nv,
    input  logic [tpti_pkg::DEN_W-1:0]          den,
    input  tpti_pkg::side_t                     side_in,
    output logic [tpti_pkg::Q_W-1:0]            qu,
    output logic [tpti_pkg::Q_W-1:0]            qv,
    output logic                                sat_u,
    output logic                                sat_v,
    output tpti_pkg::side_t                     side_out
);

    localparam int AW = tpti_pkg::ACC_W;
    localparam int BW = tpti_pkg::DEN_W + 1;
    localparam int QW = tpti_pkg::Q_W;

    logic [AW-1:0]   aua_reg;
    logic [AW-1:0]   ava_reg;
    logic [BW-1:0]   ba_reg;
    tpti_pkg::side_t sidea_reg;

    logic [AW-1:0]   au_reg [0:QW-1];
    logic [AW-1:0]   av_reg [0:QW-1];
    logic [BW-1:0]   b_reg  [0:QW-1];
    logic [QW-1:0]   qu_reg [0:QW];
    logic [QW-1:0]   qv_reg [0:QW];
    logic            su_reg [0:QW];
    logic            sv_reg [0:QW];
    tpti_pkg::side_t sd_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            aua_reg   <= (AW'(nu) << 1) + AW'(den);
            ava_reg   <= (AW'(nv) << 1) + AW'(den);
            ba_reg    <= {den, 1'b0};
            sidea_reg <= side_in;
        end
        if (en[1])
        begin
            au_reg[0] <= aua_reg;
            av_reg[0] <= ava_reg;
            b_reg[0]  <= ba_reg;
            su_reg[0] <= aua_reg >= (AW'(ba_reg) << QW);
            sv_reg[0] <= ava_reg >= (AW'(ba_reg) << QW);
            qu_reg[0] <= '0;
            qv_reg[0] <= '0;
            sd_reg[0] <= sidea_reg;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        localparam int K = QW - j;
        logic [AW-1:0] bk;
        logic          geu;
        logic          gev;

        assign bk  = AW'(b_reg[j-1]) << K;
        assign geu = au_reg[j-1] >= bk;
        assign gev = av_reg[j-1] >= bk;

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                qu_reg[j] <= qu_reg[j-1] | (geu ? (QW'(1) << K) : '0);
                qv_reg[j] <= qv_reg[j-1] | (gev ? (QW'(1) << K) : '0);
                su_reg[j] <= su_reg[j-1];
                sv_reg[j] <= sv_reg[j-1];
                sd_reg[j] <= sd_reg[j-1];
            end
        end

        if (j < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[j+1])
                begin
                    au_reg[j] <= geu ? au_reg[j-1] - bk : au_reg[j-1];
                    av_reg[j] <= gev ? av_reg[j-1] - bk : av_reg[j-1];
                    b_reg[j]  <= b_reg[j-1];
                end
            end
        end
    end

    assign qu       = qu_reg[QW];
    assign qv       = qv_reg[QW];
    assign sat_u    = su_reg[QW];
    assign sat_v    = sv_reg[QW];
    assign side_out = sd_reg[QW];

endmodule

// ===== design/triangle_pixel_texcoord_interp.sv =====
// ----------------------------------------------------------------------------
// triangle_pixel_texcoord_interp: per-pixel coverage and texcoord interpolator
// Tests one pixel against the configured triangle and returns perspective
// correct u/v and the texel index they select.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock while the output side keeps up; a
// stalled result only holds the stages behind it that are full, so empty
// stages keep taking pixels. Most of the latency is the 16-bit restoring
// divider (one quotient bit per stage) that divides the u/v numerators by the
// exact common denominator; ahead of it sit the edge products and the split
// 65/80-bit products. Write vertex and texture registers only while no pixel
// is in flight.
module triangle_pixel_texcoord_interp #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpti_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  tpti_pkg::pix_t                pix,
    output logic                          res_valid,
    input  logic                          res_ready,
    output tpti_pkg::res_t                res
);

    localparam int NS = tpti_pkg::NUM_STAGES;
    localparam int DS = tpti_pkg::DIV_STAGES;

    function automatic logic signed [16:0] sub17(input logic signed [16:0] a,
                                                 input logic signed [16:0] b);
        return a - b;
    endfunction

    function automatic logic signed [33:0] mul17(input logic signed [16:0] a,
                                                 input logic signed [16:0] b);
        return 34'(a) * 34'(b);
    endfunction

    function automatic logic signed [15:0] round_sat(input logic [15:0] q,
                                                     input logic sat,
                                                     input logic neg);
        logic signed [16:0] qs;
        logic signed [15:0] r;
        qs = signed'({1'b0, q});
        if (sat)
            r = neg ? 16'sh8000 : 16'sh7fff;
        else if (neg)
            r = (q > 16'd32768) ? 16'sh8000 : 16'(-qs);
        else
            r = (q > 16'd32767) ? 16'sh7fff : 16'(qs);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [47:0] va_pos_reg, vb_pos_reg, vc_pos_reg;
    logic [31:0] va_tex_reg, vb_tex_reg, vc_tex_reg;
    logic [12:0] tex_w_reg, tex_h_reg;
    logic        wr;
    logic [2:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_sel = paddr[tpti_pkg::ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_pos_reg <= '0;
            vb_pos_reg <= '0;
            vc_pos_reg <= '0;
            va_tex_reg <= '0;
            vb_tex_reg <= '0;
            vc_tex_reg <= '0;
            tex_w_reg  <= 13'd64;
            tex_h_reg  <= 13'd64;
        end
        else if (wr)
        begin
            case (reg_sel)
                tpti_pkg::REG_VERTEX_A_POS:   va_pos_reg <= pwdata[47:0];
                tpti_pkg::REG_VERTEX_B_POS:   vb_pos_reg <= pwdata[47:0];
                tpti_pkg::REG_VERTEX_C_POS:   vc_pos_reg <= pwdata[47:0];
                tpti_pkg::REG_VERTEX_A_TEX:   va_tex_reg <= pwdata[31:0];
                tpti_pkg::REG_VERTEX_B_TEX:   vb_tex_reg <= pwdata[31:0];
                tpti_pkg::REG_VERTEX_C_TEX:   vc_tex_reg <= pwdata[31:0];
                tpti_pkg::REG_TEXTURE_WIDTH:  tex_w_reg  <= pwdata[12:0];
                tpti_pkg::REG_TEXTURE_HEIGHT: tex_h_reg  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            tpti_pkg::REG_VERTEX_A_POS:   prdata = {16'd0, va_pos_reg};
            tpti_pkg::REG_VERTEX_B_POS:   prdata = {16'd0, vb_pos_reg};
            tpti_pkg::REG_VERTEX_C_POS:   prdata = {16'd0, vc_pos_reg};
            tpti_pkg::REG_VERTEX_A_TEX:   prdata = {32'd0, va_tex_reg};
            tpti_pkg::REG_VERTEX_B_TEX:   prdata = {32'd0, vb_tex_reg};
            tpti_pkg::REG_VERTEX_C_TEX:   prdata = {32'd0, vc_tex_reg};
            tpti_pkg::REG_TEXTURE_WIDTH:  prdata = {51'd0, tex_w_reg};
            tpti_pkg::REG_TEXTURE_HEIGHT: prdata = {51'd0, tex_h_reg};
            default:                      prdata = '0;
        endcase
    end

    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic signed [15:0] vz [0:2];
    logic signed [15:0] vu [0:2];
    logic signed [15:0] vv [0:2];

    assign ax = va_pos_reg[15:0];
    assign ay = va_pos_reg[31:16];
    assign bx = vb_pos_reg[15:0];
    assign by = vb_pos_reg[31:16];
    assign cx = vc_pos_reg[15:0];
    assign cy = vc_pos_reg[31:16];
    assign vz[0] = va_pos_reg[47:32];
    assign vz[1] = vb_pos_reg[47:32];
    assign vz[2] = vc_pos_reg[47:32];
    assign vu[0] = va_tex_reg[15:0];
    assign vu[1] = vb_tex_reg[15:0];
    assign vu[2] = vc_tex_reg[15:0];
    assign vv[0] = va_tex_reg[31:16];
    assign vv[1] = vb_tex_reg[31:16];
    assign vv[2] = vc_tex_reg[31:16];

    // ------------------------------------------------------------------
    // stage valids and advance enables
    // ------------------------------------------------------------------
    logic [NS:1] v_reg;
    logic [NS:1] v_next;
    logic [NS:1] en;

    always_comb
    begin
        en[NS] = !v_reg[NS] || res_ready;
        for (int k = NS - 1; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[1] = en[1] ? pix_valid : v_reg[1];
        for (int k = 2; k <= NS; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign pix_ready = en[1];
    assign res_valid = v_reg[NS];

    // ------------------------------------------------------------------
    // stage 1: edge products and depth pair products
    // ------------------------------------------------------------------
    logic signed [16:0] px, py;
    logic signed [33:0] m_next [0:7];
    logic signed [31:0] zz_next [0:2];
    logic               on_next;

    assign px = signed'({3'd0, pix.pixel_x, 4'd0});
    assign py = signed'({3'd0, pix.pixel_y, 4'd0});

    always_comb
    begin
        m_next[0] = mul17(sub17(px, bx), sub17(cy, by));
        m_next[1] = mul17(sub17(py, by), sub17(cx, bx));
        m_next[2] = mul17(sub17(px, cx), sub17(ay, cy));
        m_next[3] = mul17(sub17(py, cy), sub17(ax, cx));
        m_next[4] = mul17(sub17(px, ax), sub17(by, ay));
        m_next[5] = mul17(sub17(py, ay), sub17(bx, ax));
        m_next[6] = mul17(sub17(cx, ax), sub17(by, ay));
        m_next[7] = mul17(sub17(cy, ay), sub17(bx, ax));
        zz_next[0] = 32'(vz[1]) * 32'(vz[2]);
        zz_next[1] = 32'(vz[0]) * 32'(vz[2]);
        zz_next[2] = 32'(vz[0]) * 32'(vz[1]);
        on_next = ({22'd0, pix.pixel_x} < 32'(SCREEN_WIDTH))
               && ({22'd0, pix.pixel_y} < 32'(SCREEN_HEIGHT));
    end

    logic signed [33:0] m_reg  [0:7];
    logic signed [31:0] zz_reg [0:2];
    logic               on_reg;

    // stage 2 registers
    logic signed [33:0] w_reg   [0:2];
    logic signed [33:0] area_reg;
    logic signed [31:0] zz2_reg [0:2];
    logic               on2_reg;

    // stage 3
    logic signed [33:0] s3, t3, d3;
    logic signed [34:0] st3;
    logic               cov_next;
    logic               dbase_next;
    logic signed [17:0] wl3 [0:2];
    logic signed [16:0] wh3 [0:2];
    logic signed [49:0] pl_reg [0:2];
    logic signed [48:0] ph_reg [0:2];
    logic               cov3_reg, dbase3_reg;

    // stage 4
    logic signed [64:0] p_reg [0:2];
    logic               cov4_reg, dbase4_reg;

    // stage 5
    logic signed [33:0] pl5 [0:2];
    logic signed [31:0] ph5 [0:2];
    logic signed [65:0] den5_reg;
    logic signed [49:0] ul_reg [0:2];
    logic signed [47:0] uh_reg [0:2];
    logic signed [49:0] vl_reg [0:2];
    logic signed [47:0] vh_reg [0:2];
    logic               cov5_reg, dbase5_reg;

    // stage 6
    logic signed [79:0] tu_reg [0:2];
    logic signed [79:0] tv_reg [0:2];
    logic signed [65:0] den6_reg;
    tpti_pkg::side_t    side6_reg;

    // stage 7
    logic signed [80:0] nu_reg, nv_reg;
    logic signed [65:0] den7_reg;
    tpti_pkg::side_t    side7_reg;

    // stage 8
    logic [tpti_pkg::NUM_W-1:0] nu_mag_reg, nv_mag_reg;
    logic [tpti_pkg::DEN_W-1:0] den_mag_reg;
    tpti_pkg::side_t            side8_next;
    tpti_pkg::side_t            side8_reg;

    // inside test: s, t, d are the negated edge weights
    assign s3  = -w_reg[1];
    assign t3  = -w_reg[2];
    assign d3  = -w_reg[0];
    assign st3 = 35'(s3) + 35'(t3);

    always_comb
    begin
        cov_next = on2_reg
                && !(((s3 < 0) != (t3 < 0)) && (s3 != 0) && (t3 != 0))
                && ((d3 == 0) || ((d3 < 0) == (st3 <= 0)));
        dbase_next = (area_reg == 0) || (vz[0] == 0) || (vz[1] == 0) || (vz[2] == 0);
        for (int i = 0; i < 3; i++)
        begin
            wl3[i] = signed'({1'b0, w_reg[i][16:0]});
            wh3[i] = w_reg[i][33:17];
            pl5[i] = signed'({1'b0, p_reg[i][32:0]});
            ph5[i] = p_reg[i][64:33];
        end
    end

    always_comb
    begin
        side8_next = side7_reg;
        side8_next.neg_u = nu_reg[80] ^ den7_reg[65];
        side8_next.neg_v = nv_reg[80] ^ den7_reg[65];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 8; i++)
                m_reg[i] <= m_next[i];
            for (int i = 0; i < 3; i++)
                zz_reg[i] <= zz_next[i];
            on_reg <= on_next;
        end
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i]   <= m_reg[2*i] - m_reg[2*i+1];
                zz2_reg[i] <= zz_reg[i];
            end
            area_reg <= m_reg[6] - m_reg[7];
            on2_reg  <= on_reg;
        end
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= 50'(wl3[i]) * 50'(zz2_reg[i]);
                ph_reg[i] <= 49'(wh3[i]) * 49'(zz2_reg[i]);
            end
            cov3_reg   <= cov_next;
            dbase3_reg <= dbase_next;
        end
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
                p_reg[i] <= (65'(ph_reg[i]) <<< 17) + 65'(pl_reg[i]);
            cov4_reg   <= cov3_reg;
            dbase4_reg <= dbase3_reg;
        end
        if (en[5])
        begin
            den5_reg <= 66'(p_reg[0]) + 66'(p_reg[1]) + 66'(p_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                ul_reg[i] <= 50'(pl5[i]) * 50'(vu[i]);
                uh_reg[i] <= 48'(ph5[i]) * 48'(vu[i]);
                vl_reg[i] <= 50'(pl5[i]) * 50'(vv[i]);
                vh_reg[i] <= 48'(ph5[i]) * 48'(vv[i]);
            end
            cov5_reg   <= cov4_reg;
            dbase5_reg <= dbase4_reg;
        end
        if (en[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                tu_reg[i] <= (80'(uh_reg[i]) <<< 33) + 80'(ul_reg[i]);
                tv_reg[i] <= (80'(vh_reg[i]) <<< 33) + 80'(vl_reg[i]);
            end
            den6_reg             <= den5_reg;
            side6_reg.covered    <= cov5_reg;
            side6_reg.degenerate <= dbase5_reg || (den5_reg == 0);
            side6_reg.live       <= cov5_reg && !dbase5_reg && (den5_reg != 0);
            side6_reg.neg_u      <= 1'b0;
            side6_reg.neg_v      <= 1'b0;
        end
        if (en[7])
        begin
            nu_reg    <= 81'(tu_reg[0]) + 81'(tu_reg[1]) + 81'(tu_reg[2]);
            nv_reg    <= 81'(tv_reg[0]) + 81'(tv_reg[1]) + 81'(tv_reg[2]);
            den7_reg  <= den6_reg;
            side7_reg <= side6_reg;
        end
        if (en[8])
        begin
            nu_mag_reg  <= nu_reg[80]   ? 80'(-nu_reg)   : 80'(nu_reg);
            nv_mag_reg  <= nv_reg[80]   ? 80'(-nv_reg)   : 80'(nv_reg);
            den_mag_reg <= den7_reg[65] ? 65'(-den7_reg) : 65'(den7_reg);
            side8_reg   <= side8_next;
        end
    end

    // ------------------------------------------------------------------
    // stages 9..26: rounding divider
    // ------------------------------------------------------------------
    logic [tpti_pkg::Q_W-1:0] qu, qv;
    logic                     sat_u, sat_v;
    tpti_pkg::side_t          side_div;

    tpti_div u_div (
        .clk      (clk),
        .en       (en[8+DS:9]),
        .nu       (nu_mag_reg),
        .nv       (nv_mag_reg),
        .den      (den_mag_reg),
        .side_in  (side8_reg),
        .qu       (qu),
        .qv       (qv),
        .sat_u    (sat_u),
        .sat_v    (sat_v),
        .side_out (side_div)
    );

    // ------------------------------------------------------------------
    // stages 27..30: saturate, texel column/row, index
    // ------------------------------------------------------------------
    logic signed [15:0] tu27_reg, tv27_reg;
    tpti_pkg::side_t    side27_reg;
    logic signed [29:0] pu_reg, pv_reg;
    logic signed [15:0] tu28_reg, tv28_reg;
    tpti_pkg::side_t    side28_reg;
    logic [29:0]        mag_u, mag_v;
    logic [16:0]        col_next, row_next;
    logic               ok_next;
    logic [16:0]        col_reg, row_reg;
    logic               ok_reg;
    logic signed [15:0] tu29_reg, tv29_reg;
    tpti_pkg::side_t    side29_reg;
    logic [29:0]        idx_next;
    tpti_pkg::res_t     res_reg;

    always_comb
    begin
        mag_u    = pu_reg[29] ? 30'(-pu_reg) : 30'(pu_reg);
        mag_v    = pv_reg[29] ? 30'(-pv_reg) : 30'(pv_reg);
        col_next = mag_u[28:12];
        row_next = mag_v[28:12];
        // a negative coordinate is in range only when it truncates to zero
        ok_next  = (!pu_reg[29] || (col_next == '0)) && (col_next < 17'(tex_w_reg))
                && (!pv_reg[29] || (row_next == '0)) && (row_next < 17'(tex_h_reg));
        idx_next = 30'(row_reg) * 30'(tex_w_reg) + 30'(col_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[27])
        begin
            tu27_reg   <= side_div.live ? round_sat(qu, sat_u, side_div.neg_u) : '0;
            tv27_reg   <= side_div.live ? round_sat(qv, sat_v, side_div.neg_v) : '0;
            side27_reg <= side_div;
        end
        if (en[28])
        begin
            pu_reg     <= 30'(tu27_reg) * 30'(signed'({1'b0, tex_w_reg}));
            pv_reg     <= 30'(tv27_reg) * 30'(signed'({1'b0, tex_h_reg}));
            tu28_reg   <= tu27_reg;
            tv28_reg   <= tv27_reg;
            side28_reg <= side27_reg;
        end
        if (en[29])
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            ok_reg     <= ok_next;
            tu29_reg   <= tu28_reg;
            tv29_reg   <= tv28_reg;
            side29_reg <= side28_reg;
        end
        if (en[30])
        begin
            res_reg.covered     <= side29_reg.covered;
            res_reg.degenerate  <= side29_reg.degenerate;
            res_reg.tex_u       <= tu29_reg;
            res_reg.tex_v       <= tv29_reg;
            res_reg.texel_index <= ok_reg ? idx_next[23:0] : '0;
        end
    end

    assign res = res_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (!res.covered || res.degenerate)
        |-> (res.tex_u == 0) && (res.tex_v == 0) && (res.texel_index == 0))
        else $error("texcoord output not zero for uncovered or degenerate pixel");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> v_reg[1] && v_reg[NS])
        else $error("pixel refused while pipeline has room");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] && !en[NS-1] |=> v_reg[NS-1] && v_reg[NS])
        else $error("stalled beat dropped");

endmodule
